[design/mus_pkg.sv]
// shared types and constants for the market update stream parser
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package mus_pkg;

    // parse phases, one per field group of the byte stream
    typedef enum logic [2:0] {
        PH_HDR,
        PH_SLEN,
        PH_TYPE,
        PH_SYM,
        PH_LVL,
        PH_SIZE,
        PH_PRICE,
        PH_SKIP
    } phase_t;

    localparam logic [7:0] TYPE_TRADE = 8'h54;   // 'T'
    localparam logic [7:0] TYPE_QUOTE = 8'h51;   // 'Q'

    // bytes of a segment consumed before skipping (length bytes included)
    localparam logic [15:0] LEN_BYTES      = 16'd2;
    localparam logic [15:0] TRADE_BODY     = 16'd16;
    localparam logic [15:0] QUOTE_BODY     = 16'd18;
    localparam logic [15:0] UNKNOWN_USED   = LEN_BYTES + 16'd1;
    localparam logic [15:0] TRADE_USED     = LEN_BYTES + TRADE_BODY;
    localparam logic [15:0] QUOTE_USED     = LEN_BYTES + QUOTE_BODY;

    // last byte index of each multi-byte field, and the index of the header's first count byte
    localparam logic [2:0] HDR_CNT_FIRST = 3'd2;
    localparam logic [2:0] HDR_LAST      = 3'd3;
    localparam logic [2:0] HALF_LAST     = 3'd1;
    localparam logic [2:0] SYM_LAST      = 3'd4;
    localparam logic [2:0] PRICE_LAST    = 3'd7;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_QUOTE = 1'b1;

    // register map, word index
    localparam logic REG_EMIT_QUOTES = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [39:0] symbol;
        logic [15:0] level;
        logic [15:0] qty;
        logic [63:0] price;
    } record_t;

endpackage

`default_nettype wire

[design/market_update_stream_parser.sv]
// market update stream parser: one byte beat in per cycle, a record per trade or enabled quote
// a record is registered onto out_valid when the parser steps on its last price byte
// throughput: one byte per cycle; the input stage stalls only while a record waits on out_ready
// reset: rst_n clears both valid flags, the parse phase (expects a packet header) and
// emit_quotes; the byte and record payload registers are not reset
// depends on mus_pkg, mus_cfg_regs and mus_field_parser
`default_nettype none

module market_update_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // byte stream in
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,

    // parsed records out
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             record_kind,
    output logic [39:0]      symbol_chars,
    output logic [15:0]      book_level,
    output logic [15:0]      quantity,
    output logic [63:0]      price_units,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // input register: holds one byte beat ahead of the parser
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;

    // result register: one record waiting for the consumer
    logic             out_valid_reg, out_valid_next;
    mus_pkg::record_t out_rec_reg, out_rec_next;

    logic             advance;
    logic             in_take;
    logic             emit_quotes;
    logic             rec_valid;
    mus_pkg::record_t rec;

    assign pready = 1'b1;

    mus_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .emit_quotes (emit_quotes)
    );

    // the parser steps whenever a byte is held and the result slot is free
    // or is being emptied in the same cycle
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    mus_field_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .in_byte     (in_byte_reg),
        .emit_quotes (emit_quotes),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = data_byte;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // a new record can only land when the slot is free or drained this cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        if (advance && rec_valid)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = rec;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_rec_reg <= out_rec_next;
    end

    assign out_valid    = out_valid_reg;
    assign record_kind  = out_rec_reg.kind;
    assign symbol_chars = out_rec_reg.symbol;
    assign book_level   = out_rec_reg.level;
    assign quantity     = out_rec_reg.qty;
    assign price_units  = out_rec_reg.price;

endmodule

`default_nettype wire

[design/mus_cfg_regs.sv]
// configuration register file with the apb-style write and read port
// depends on mus_pkg for the register map
`default_nettype none

module mus_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             emit_quotes
);

    logic emit_quotes_reg;
    logic emit_quotes_next;
    logic wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr[2] == mus_pkg::REG_EMIT_QUOTES);

    always_comb
    begin
        emit_quotes_next = emit_quotes_reg;
        if (wr_hit)
        begin
            emit_quotes_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_quotes_reg <= 1'b0;
        end
        else
        begin
            emit_quotes_reg <= emit_quotes_next;
        end
    end

    // low address bits select bytes within the word and are ignored
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == mus_pkg::REG_EMIT_QUOTES && paddr[1:0] == 2'd0)
        begin
            prdata = {31'd0, emit_quotes_reg};
        end
        else if (paddr[2] == mus_pkg::REG_EMIT_QUOTES)
        begin
            prdata = {31'd0, emit_quotes_reg};
        end
    end

    assign emit_quotes = emit_quotes_reg;

endmodule

`default_nettype wire

[design/mus_field_parser.sv]
// byte-at-a-time parser state machine and field accumulators
// depends on mus_pkg for phases, type codes and the record struct
`default_nettype none

module mus_field_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire logic       emit_quotes,
    output logic            rec_valid,
    output mus_pkg::record_t rec
);

    mus_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] upd_reg, upd_next;
    logic [15:0] seg_reg, seg_next;
    logic [15:0] skip_reg, skip_next;
    logic        quote_reg, quote_next;
    logic [39:0] sym_reg, sym_next;
    logic [15:0] lvl_reg, lvl_next;
    logic [15:0] size_reg, size_next;
    logic [63:0] price_reg, price_next;

    logic        try_skip;
    logic        finish;
    logic [15:0] consumed;
    logic [15:0] skip_dec;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        upd_next   = upd_reg;
        seg_next   = seg_reg;
        skip_next  = skip_reg;
        quote_next = quote_reg;
        sym_next   = sym_reg;
        lvl_next   = lvl_reg;
        size_next  = size_reg;
        price_next = price_reg;
        rec_valid  = 1'b0;
        try_skip   = 1'b0;
        finish     = 1'b0;
        consumed   = 16'd0;
        skip_dec   = skip_reg;

        rec.kind   = quote_reg;
        rec.symbol = sym_reg;
        rec.level  = quote_reg ? lvl_reg : 16'd0;
        rec.qty    = size_reg;
        rec.price  = {price_reg[55:0], in_byte};

        if (step)
        begin
            unique case (phase_reg)
                mus_pkg::PH_HDR:
                begin
                    if (idx_reg >= mus_pkg::HDR_CNT_FIRST)
                    begin
                        upd_next = {upd_reg[7:0], in_byte};
                    end
                    if (idx_reg >= mus_pkg::HDR_LAST)
                    begin
                        idx_next   = 3'd0;
                        phase_next = (upd_next == 16'd0) ? mus_pkg::PH_HDR : mus_pkg::PH_SLEN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                mus_pkg::PH_SLEN:
                begin
                    seg_next = {seg_reg[7:0], in_byte};
                    if (idx_reg >= mus_pkg::HALF_LAST)
                    begin
                        idx_next   = 3'd0;
                        phase_next = mus_pkg::PH_TYPE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                mus_pkg::PH_TYPE:
                begin
                    quote_next = (in_byte == mus_pkg::TYPE_QUOTE);
                    idx_next   = 3'd0;
                    if (in_byte == mus_pkg::TYPE_TRADE || in_byte == mus_pkg::TYPE_QUOTE)
                    begin
                        phase_next = mus_pkg::PH_SYM;
                    end
                    else
                    begin
                        try_skip = 1'b1;
                        consumed = mus_pkg::UNKNOWN_USED;
                    end
                end
                mus_pkg::PH_SYM:
                begin
                    sym_next = {sym_reg[31:0], in_byte};
                    if (idx_reg >= mus_pkg::SYM_LAST)
                    begin
                        idx_next   = 3'd0;
                        phase_next = quote_reg ? mus_pkg::PH_LVL : mus_pkg::PH_SIZE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                mus_pkg::PH_LVL:
                begin
                    lvl_next = {lvl_reg[7:0], in_byte};
                    if (idx_reg >= mus_pkg::HALF_LAST)
                    begin
                        idx_next   = 3'd0;
                        phase_next = mus_pkg::PH_SIZE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                mus_pkg::PH_SIZE:
                begin
                    size_next = {size_reg[7:0], in_byte};
                    if (idx_reg >= mus_pkg::HALF_LAST)
                    begin
                        idx_next   = 3'd0;
                        phase_next = mus_pkg::PH_PRICE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                mus_pkg::PH_PRICE:
                begin
                    price_next = {price_reg[55:0], in_byte};
                    if (idx_reg >= mus_pkg::PRICE_LAST)
                    begin
                        rec_valid = !quote_reg || emit_quotes;
                        try_skip  = 1'b1;
                        consumed  = quote_reg ? mus_pkg::QUOTE_USED : mus_pkg::TRADE_USED;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                mus_pkg::PH_SKIP:
                begin
                    if (skip_reg != 16'd0)
                    begin
                        skip_dec = skip_reg - 16'd1;
                    end
                    skip_next = skip_dec;
                    finish    = (skip_dec == 16'd0);
                end
            endcase

            // trailing bytes of the segment, clamped at zero
            if (try_skip)
            begin
                idx_next = 3'd0;
                if (seg_reg > consumed)
                begin
                    skip_next  = seg_reg - consumed;
                    phase_next = mus_pkg::PH_SKIP;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            // end of update: next segment or a new packet header
            if (finish)
            begin
                upd_next   = upd_reg - 16'd1;
                idx_next   = 3'd0;
                phase_next = (upd_next == 16'd0) ? mus_pkg::PH_HDR : mus_pkg::PH_SLEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mus_pkg::PH_HDR;
            idx_reg   <= 3'd0;
            upd_reg   <= 16'd0;
            seg_reg   <= 16'd0;
            skip_reg  <= 16'd0;
            quote_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            upd_reg   <= upd_next;
            seg_reg   <= seg_next;
            skip_reg  <= skip_next;
            quote_reg <= quote_next;
        end
    end

    // field accumulators are fully rewritten before any use
    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        lvl_reg   <= lvl_next;
        size_reg  <= size_next;
        price_reg <= price_next;
    end

endmodule

`default_nettype wire

[design/mus_checker.sv]
// port-level checker for the market update stream parser, bound to the top level
// depends on mus_pkg for the record kind codes
`default_nettype none

module mus_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        record_kind,
    input wire logic [39:0] symbol_chars,
    input wire logic [15:0] book_level,
    input wire logic [15:0] quantity,
    input wire logic [63:0] price_units
);

    // a waiting record holds still until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_kind)
            && $stable(symbol_chars) && $stable(book_level)
            && $stable(quantity) && $stable(price_units))
        else $error("record changed while stalled");

    // trade records carry no book level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == mus_pkg::KIND_TRADE |-> book_level == 16'd0)
        else $error("trade record with nonzero level");

    // input back-pressure only comes from a stalled record
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending record");

    // records are many bytes apart, so a taken record is never followed at once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("back-to-back records");

endmodule

bind market_update_stream_parser mus_checker u_mus_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_kind  (record_kind),
    .symbol_chars (symbol_chars),
    .book_level   (book_level),
    .quantity     (quantity),
    .price_units  (price_units)
);

`default_nettype wire
